[design/ecpr_pkg.sv]
// ----------------------------------------------------------------------------
// ecpr_pkg: shared types and codes for the clock page replacement block
// Holds the command and result codes, parameter defaults and the transaction
// structs that travel on the input and result ports.
// ----------------------------------------------------------------------------
package ecpr_pkg;

  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 20;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SWAP_W  = 21;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RETAG  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_WB     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] page_number;
    logic              is_write;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] frame_slot;
    logic [PAGE_W-1:0] victim_page;
    logic [SWAP_W-1:0] swap_slot;
    logic              last;
  } out_t;

endpackage

[design/ecpr_ram.sv]
// ----------------------------------------------------------------------------
// ecpr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ecpr_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/enhanced_clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// enhanced_clock_page_replacement: enhanced second-chance clock replacement
// Insert, access and retag give a single result, strobed the cycle after start.
// An evict walks the ring from the clock hand, clearing A one frame per cycle;
// an unreferenced frame takes a page RAM read and gives a write-back if dirty,
// else the victim that ends the walk. Results strobe as they form.
// busy is high for the whole walk. The receiver cannot stall the result port.
// Synchronous active-low reset clears A/D bits, count, hand and full flag.
// ----------------------------------------------------------------------------
module enhanced_clock_page_replacement
  import ecpr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  // Widths derived from the ring size and the page width.
  localparam int unsigned HW      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW      = $clog2(FRAMES + 1);
  localparam int unsigned CMPW    = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int unsigned SXW     = (HW > SLOT_W) ? HW : SLOT_W;
  localparam int unsigned STORE_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  // Sequencer codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [HW-1:0]     hand_r, hand_nxt;
  logic              full_r, full_nxt;
  logic [FRAMES-1:0] acc_r, acc_nxt;
  logic [FRAMES-1:0] dirty_r, dirty_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic               ram_we;
  logic [HW-1:0]      ram_waddr;
  logic [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0] ram_rdata;

  logic          accept;
  logic [HW-1:0] slot_idx;
  logic [SXW-1:0] slot_ext;
  logic          slot_bad;
  logic [CW-1:0] hand_inc;
  logic [HW-1:0] hand_adv;

  // Page store: written by insert and retag, read at the hand during a walk.
  ecpr_ram #(
    .WIDTH(STORE_W),
    .DEPTH(FRAMES)
  ) u_page_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(hand_r),
    .rdata(ram_rdata)
  );

  assign accept   = start && (state_r == ST_IDLE);
  assign slot_ext = SXW'(in_item.slot);
  assign slot_idx = slot_ext[HW-1:0];
  assign slot_bad = CMPW'(in_item.slot) >= CMPW'(count_r);

  // Advance the hand with wrap at the ring's fill level.
  assign hand_inc = CW'(hand_r) + CW'(1);
  assign hand_adv = (hand_inc >= count_r) ? '0 : HW'(hand_inc);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    hand_nxt      = hand_r;
    full_nxt      = full_r;
    acc_nxt       = acc_r;
    dirty_nxt     = dirty_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    ram_we        = 1'b0;
    ram_waddr     = HW'(count_r);
    ram_wdata     = STORE_W'(in_item.page_number);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_nxt.last  = 1'b1;
          out_nxt.kind  = KIND_ACK;
          case (in_item.cmd)
            CMD_INSERT: begin
              // Once an evict has started a walk, inserts are acknowledged and dropped.
              if (!full_r) begin
                if (count_r >= CW'(FRAMES)) begin
                  out_nxt.kind = KIND_ERR;
                end else begin
                  ram_we                       = 1'b1;
                  acc_nxt[HW'(count_r)]   = 1'b0;
                  dirty_nxt[HW'(count_r)] = 1'b0;
                  count_nxt                    = count_r + CW'(1);
                end
              end
            end
            CMD_ACCESS: begin
              if (slot_bad) begin
                out_nxt.kind = KIND_ERR;
              end else begin
                acc_nxt[slot_idx] = 1'b1;
                if (in_item.is_write) begin
                  dirty_nxt[slot_idx] = 1'b1;
                end
              end
            end
            CMD_RETAG: begin
              if (slot_bad) begin
                out_nxt.kind = KIND_ERR;
              end else begin
                ram_we              = 1'b1;
                ram_waddr           = slot_idx;
                acc_nxt[slot_idx]   = 1'b0;
                dirty_nxt[slot_idx] = 1'b0;
              end
            end
            default: begin
              // Evict: error on an empty ring, else start the walk.
              if (count_r == '0) begin
                out_nxt.kind = KIND_ERR;
              end else begin
                out_valid_nxt = 1'b0;
                full_nxt      = 1'b1;
                state_nxt     = ST_SCAN;
                if (CW'(hand_r) >= count_r) begin
                  hand_nxt = '0;
                end
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Referenced frame gets its second chance; otherwise fetch its page.
        if (acc_r[hand_r]) begin
          acc_nxt[hand_r] = 1'b0;
          hand_nxt        = hand_adv;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.frame_slot  = SLOT_W'(hand_r);
        out_nxt.victim_page = PAGE_W'(ram_rdata);
        hand_nxt            = hand_adv;
        if (dirty_r[hand_r]) begin
          out_nxt.kind      = KIND_WB;
          out_nxt.swap_slot = SWAP_W'(ram_rdata) + SWAP_W'(1);
          dirty_nxt[hand_r] = 1'b0;
          state_nxt         = ST_SCAN;
        end else begin
          out_nxt.kind = KIND_VICTIM;
          out_nxt.last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      hand_r      <= '0;
      full_r      <= 1'b0;
      acc_r       <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hand_r      <= hand_nxt;
      full_r      <= full_nxt;
      acc_r       <= acc_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset, qualified by the strobe.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Single-result commands answer on the very next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd != CMD_EVICT) |=> (out_valid && out_item.last))
    else $error("single-result command did not answer next cycle");

  // A write-back never closes a transaction; a victim always does.
  a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind == KIND_WB) |-> !out_item.last)
    else $error("write-back flagged as last");

  a_victim_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind == KIND_VICTIM) |-> out_item.last)
    else $error("victim not flagged as last");

  // The hand stays inside the filled part of the ring.
  a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (CW'(hand_r) < count_r))
    else $error("clock hand beyond ring fill");

  // The full flag is set only by an evict on a non-empty ring.
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (count_r != '0))
    else $error("full flag set on empty ring");

endmodule

[test/tb_enhanced_clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// tb_enhanced_clock_page_replacement: self-checking bench for the clock pager
// Runs a directed opening through the error and ignore paths while the ring
// fills to its full size. It then runs random bursts of accesses and retags,
// each closed by an evict, with inserts mixed in as noise. An in-bench
// predictor of the ring, its A/D bits and the clock hand builds the expected
// result stream, and a monitor checks every strobed result field by field.
// ----------------------------------------------------------------------------
module tb_enhanced_clock_page_replacement;
  import ecpr_pkg::*;

  localparam int unsigned RING        = FRAMES_DEF;
  localparam int unsigned N_RANDOM    = 200;
  localparam int unsigned MAX_GAP     = 18;
  // Allow for the longest evict walk plus margin once the last expected
  // result has landed.
  localparam int unsigned TAIL_CYCLES = 3 * RING + 12;
  // Cycles with no accepted transaction on either side before giving up.
  localparam int unsigned STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  enhanced_clock_page_replacement dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow of the ring: page per frame, accessed and dirty bits, fill count,
  // clock hand and the sealed flag that the first evict on a non-empty ring raises.
  // --------------------------------------------------------------------------
  logic [PAGE_W-1:0] frame_page [RING];
  bit                frame_ref  [RING];
  bit                frame_mod  [RING];
  int unsigned       ring_len   = 0;
  int unsigned       hand       = 0;
  bit                sealed     = 1'b0;

  out_t pending_results [$];   // expected results, oldest first
  in_t  cmd_backlog     [$];   // commands not yet presented to the block

  int unsigned fails        = 0;
  int unsigned n_cmds       = 0;
  int unsigned n_evicts     = 0;
  int unsigned n_results    = 0;
  int unsigned n_writebacks = 0;
  int unsigned n_victims    = 0;
  int unsigned n_errors     = 0;
  int unsigned longest_walk = 0;

  function automatic out_t single_result(logic [KIND_W-1:0] kind);
    out_t r;
    r = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  // Advance the shadow ring by one accepted command and queue the results
  // it must produce.
  task automatic apply_command(input in_t c);
    out_t        r;
    int unsigned h;
    int unsigned step;
    int unsigned walk;
    bit          found;
    begin
      n_cmds++;
      case (c.cmd)
        CMD_INSERT: begin
          // Once sealed, inserts are acknowledged and dropped.
          if (sealed) begin
            pending_results.push_back(single_result(KIND_ACK));
          end else if (ring_len >= RING) begin
            pending_results.push_back(single_result(KIND_ERR));
          end else begin
            frame_page[ring_len] = c.page_number;
            frame_ref[ring_len]  = 1'b0;
            frame_mod[ring_len]  = 1'b0;
            ring_len++;
            pending_results.push_back(single_result(KIND_ACK));
          end
        end
        CMD_ACCESS, CMD_RETAG: begin
          if (c.slot >= ring_len) begin
            pending_results.push_back(single_result(KIND_ERR));
          end else if (c.cmd == CMD_ACCESS) begin
            frame_ref[c.slot] = 1'b1;
            if (c.is_write) frame_mod[c.slot] = 1'b1;
            pending_results.push_back(single_result(KIND_ACK));
          end else begin
            // Swap-in reloads the frame clean and unreferenced.
            frame_page[c.slot] = c.page_number;
            frame_ref[c.slot]  = 1'b0;
            frame_mod[c.slot]  = 1'b0;
            pending_results.push_back(single_result(KIND_ACK));
          end
        end
        default: begin
          n_evicts++;
          if (ring_len == 0) begin
            // Empty ring: error, and the sealed flag stays down.
            pending_results.push_back(single_result(KIND_ERR));
          end else begin
            sealed = 1'b1;
            h = (hand >= ring_len) ? 0 : hand;
            step = 0;
            walk = 0;
            found = 1'b0;
            // Sweep: clear A, write back dirty frames, stop on the first
            // clean unreferenced frame and park the hand just past it.
            while (!found && step < 3 * ring_len + 1) begin
              if (frame_ref[h]) begin
                frame_ref[h] = 1'b0;
              end else if (frame_mod[h]) begin
                r = '0;
                r.kind        = KIND_WB;
                r.frame_slot  = h[SLOT_W-1:0];
                r.victim_page = frame_page[h];
                r.swap_slot   = {1'b0, frame_page[h]} + 1'b1;
                pending_results.push_back(r);
                frame_mod[h] = 1'b0;
                walk++;
              end else begin
                r = '0;
                r.kind        = KIND_VICTIM;
                r.frame_slot  = h[SLOT_W-1:0];
                r.victim_page = frame_page[h];
                r.last        = 1'b1;
                pending_results.push_back(r);
                walk++;
                found = 1'b1;
              end
              h = (h + 1 >= ring_len) ? 0 : h + 1;
              step++;
            end
            hand = h;
            if (walk > longest_walk) longest_walk = walk;
          end
        end
      endcase
    end
  endtask

  function automatic in_t make_cmd(logic [CMD_W-1:0] cmd, int unsigned slot,
                                   logic [PAGE_W-1:0] page, bit wr);
    in_t c;
    c.cmd         = cmd;
    c.slot        = slot[SLOT_W-1:0];
    c.page_number = page;
    c.is_write    = wr;
    return c;
  endfunction

  // Mostly random pages, with a fair share of the all-zero and all-one ends.
  function automatic logic [PAGE_W-1:0] pick_page();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return PAGE_W'($urandom());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present backlog commands on start/in_item. Each command waits a
  // random idle gap first, except inside no-idle stretches.
  // --------------------------------------------------------------------------
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  function automatic int unsigned draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(5, 20);
    return $urandom_range(0, MAX_GAP);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = $urandom_range(0, MAX_GAP);
    end else if (start && !busy) begin
      // Transaction accepted: predict it, then hold start high only if the
      // next command goes out back to back.
      apply_command(in_item);
      gap_left = draw_gap();
      if (gap_left == 0 && cmd_backlog.size() > 0) begin
        in_item <= cmd_backlog.pop_front();
        gap_left = draw_gap();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0) begin
        in_item <= cmd_backlog.pop_front();
        start   <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest expectation.
  // --------------------------------------------------------------------------
  out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with none expected: kind=%0d slot=%0d page=%0h",
               out_item.kind, out_item.frame_slot, out_item.victim_page);
        fails++;
      end else begin
        want = pending_results.pop_front();
        case (want.kind)
          KIND_WB:     n_writebacks++;
          KIND_VICTIM: n_victims++;
          KIND_ERR:    n_errors++;
          default:     ;
        endcase
        if (out_item.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
          fails++;
        end
        if (out_item.frame_slot !== want.frame_slot) begin
          $error("frame_slot: expected %0d, got %0d", want.frame_slot,
                 out_item.frame_slot);
          fails++;
        end
        if (out_item.victim_page !== want.victim_page) begin
          $error("victim_page: expected %0h, got %0h", want.victim_page,
                 out_item.victim_page);
          fails++;
        end
        if (out_item.swap_slot !== want.swap_slot) begin
          $error("swap_slot: expected %0h, got %0h", want.swap_slot,
                 out_item.swap_slot);
          fails++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          fails++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither side moves a transaction for too long.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  int unsigned counted;
  int unsigned burst_len;
  int unsigned pick;

  initial begin
    // Directed opening, from an empty ring to a sealed full one.
    // Evict, access and retag on an empty ring all fail.
    cmd_backlog.push_back(make_cmd(CMD_EVICT, 0, '0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_ACCESS, 0, '0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_RETAG, 15, '1, 1'b1));
    // One page in: slot 1 is still out of range, slot 0 is fine.
    cmd_backlog.push_back(make_cmd(CMD_INSERT, 0, '0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_ACCESS, 1, '1, 1'b1));
    cmd_backlog.push_back(make_cmd(CMD_ACCESS, 0, '0, 1'b1));
    // Fill to the full ring; the last page is all ones.
    for (int unsigned i = 1; i < RING - 1; i++) begin
      cmd_backlog.push_back(make_cmd(CMD_INSERT, 0, PAGE_W'($urandom()), 1'b0));
    end
    cmd_backlog.push_back(make_cmd(CMD_INSERT, 15, '1, 1'b1));
    // Insert into a full but unsealed ring fails.
    cmd_backlog.push_back(make_cmd(CMD_INSERT, 0, 20'h5a5a5, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_RETAG, 1, '0, 1'b0));
    cmd_backlog.push_back(make_cmd(CMD_ACCESS, 15, '1, 1'b1));
    // First evict seals the ring: slot 0 loses A, slot 1 is the victim.
    cmd_backlog.push_back(make_cmd(CMD_EVICT, 0, '0, 1'b0));
    // Sealed: insert is acknowledged and dropped.
    cmd_backlog.push_back(make_cmd(CMD_INSERT, 3, '1, 1'b0));
    // Second evict takes slot 2, the next clean unreferenced frame, as the victim.
    cmd_backlog.push_back(make_cmd(CMD_EVICT, 0, '0, 1'b0));

    // Random part: bursts of accesses and retags, each closed by an evict.
    // Now and then every frame is written first, forcing the longest walk.
    counted = 0;
    while (counted < N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int unsigned s = 0; s < RING; s++) begin
          cmd_backlog.push_back(make_cmd(CMD_ACCESS, s, PAGE_W'($urandom()), 1'b1));
        end
        counted += RING;
      end else begin
        burst_len = $urandom_range(0, 12);
        repeat (burst_len) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            cmd_backlog.push_back(make_cmd(CMD_ACCESS, $urandom_range(0, RING - 1),
                                           PAGE_W'($urandom()),
                                           1'($urandom_range(0, 1))));
          end else if (pick < 9) begin
            cmd_backlog.push_back(make_cmd(CMD_RETAG, $urandom_range(0, RING - 1),
                                           pick_page(), 1'($urandom_range(0, 1))));
          end else begin
            // Noise: ignored once sealed.
            cmd_backlog.push_back(make_cmd(CMD_INSERT, $urandom_range(0, RING - 1),
                                           pick_page(), 1'($urandom_range(0, 1))));
          end
          counted++;
        end
      end
      cmd_backlog.push_back(make_cmd(CMD_EVICT, $urandom_range(0, RING - 1),
                                     PAGE_W'($urandom()), 1'($urandom_range(0, 1))));
      counted++;
    end

    // Hold reset, then release it for good.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every command accepted and every expected result seen.
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || pending_results.size() != 0);
    // Give a stray trailing result time to show up.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d commands (%0d evicts) and %0d results: %0d write-backs,",
             n_cmds, n_evicts, n_results, n_writebacks);
    $display("%0d victims, %0d errors; longest evict gave %0d results.",
             n_victims, n_errors, longest_walk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/ecpr_pkg.sv
design/ecpr_ram.sv
design/enhanced_clock_page_replacement.sv
test/tb_enhanced_clock_page_replacement.sv
